### src/page_frame_bitmap_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame bitmap allocator
// Clocked, reset-qualified property checks used by the datapath.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Property must hold at every rising edge outside reset.
`define PFBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define PFBA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### src/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Constants, types and helper functions of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_BYTES = 4096;
  localparam int MAP_BYTES   = (FRAME_COUNT + 7) / 8;
  localparam int MAP_AW      = $clog2(MAP_BYTES);

  // fixed field widths
  localparam int FRAME_W = 10;
  localparam int FADDR_W = 22;

  // start-up reservations, in bytes and in frames
  localparam int KERNEL_END    = 32'h0002_0000;
  localparam int HOLE_START    = 32'h000A_0000;
  localparam int HOLE_END      = 32'h0010_0000;
  localparam int KERNEL_FRAMES = KERNEL_END / FRAME_BYTES;
  localparam int HOLE_FIRST    = HOLE_START / FRAME_BYTES;
  localparam int HOLE_LAST     = HOLE_END / FRAME_BYTES;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RESERVE = 1'b1
  } command_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // input transfer taken
    logic scan_step;  // advance to next bitmap byte
    logic commit;     // write bitmap byte and set result
    logic out_load;   // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_reserve;  // incoming item is a reserve
    logic in_range;    // incoming frame index exists
    logic byte_free;   // current byte has a free frame
    logic last_byte;   // current byte is the last of the map
    logic slot_free;   // output register can take a result
  } status_t;

  // bitmap byte as left by the start-up reservations
  function automatic logic [7:0] reset_byte(input logic [MAP_AW-1:0] k);
    logic [7:0] v;
    int         f;
    v = '0;
    for (int b = 0; b < 8; b++) begin
      f = int'(k) * 8 + b;
      v[b] = (f < FRAME_COUNT) &&
             ((f < KERNEL_FRAMES) || ((f >= HOLE_FIRST) && (f < HOLE_LAST)));
    end
    return v;
  endfunction

  // bits past the end of the map count as used
  function automatic logic [7:0] pad_mask(input logic [MAP_AW-1:0] k);
    logic [7:0] v;
    v = '0;
    for (int b = 0; b < 8; b++) begin
      v[b] = (int'(k) * 8 + b) >= FRAME_COUNT;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/page_frame_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top
// Used/free bitmap over physical page frames with lowest-free allocation.
// ----------------------------------------------------------------------------
// Requests come in on the s_axis channel: tuser is the command (0 allocate the
// lowest free frame, 1 reserve the frame in tdata[9:0]). Each request gives one
// result on m_axis: tuser is ok, tdata holds page number and frame address.
// Allocate scans the bitmap one byte per cycle through the memory read port
// until it finds a byte with a free frame or reaches the last byte (map full).
// A reserve writes its byte, then loads the result; an out-of-range reserve
// loads a failed result without a write. The next request is taken the cycle
// after the result loads.
// One request is in work at a time; a new request is taken once the previous
// result sits in the output register, even while it waits there.
// When the receiver stalls, the finished result is held and the block stops
// before loading the next one. Reset restores the start-up reservations
// (kernel frames below 0x20000 and the hole 0xA0000 to 0x100000) at once via
// per-byte valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] frame_index, [15:10] zero
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [9:0] page_number, [31:10] frame_address
  output logic             m_axis_tuser    // [0] ok
);

  pfba_pkg::cmd_t                  cmd;
  pfba_pkg::status_t               stat;
  logic [pfba_pkg::FRAME_W-1:0]    page;
  logic [pfba_pkg::FADDR_W-1:0]    faddr;

  pfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfba_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_command_i (s_axis_tuser),
    .in_index_i   (s_axis_tdata[pfba_pkg::FRAME_W-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_ok_o     (m_axis_tuser),
    .out_page_o   (page),
    .out_faddr_o  (faddr)
  );

  assign m_axis_tdata = {faddr, page};

endmodule

`default_nettype wire

### src/pfba_ctrl.sv
// ----------------------------------------------------------------------------
// pfba_ctrl
// Sequencer: takes one request, drives the byte scan or reserve, hands off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfba_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pfba_pkg::status_t stat_i,
  output pfba_pkg::cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RSV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!stat_i.in_reserve) begin
            state_d = ST_SCAN;
          end else if (stat_i.in_range) begin
            state_d = ST_RSV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.byte_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_OUT;
        end else if (stat_i.last_byte) begin
          state_d = ST_OUT;  // map full
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_RSV: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/pfba_datapath.sv
// ----------------------------------------------------------------------------
// pfba_datapath
// Bitmap memory with per-byte valid bits, scan pointer, result and output regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "page_frame_bitmap_allocator_top_assert.svh"

module pfba_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_command_i,
  input  wire logic [pfba_pkg::FRAME_W-1:0]    in_index_i,
  input  wire pfba_pkg::cmd_t                  cmd_i,
  output pfba_pkg::status_t                    stat_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_ok_o,
  output logic [pfba_pkg::FRAME_W-1:0]         out_page_o,
  output logic [pfba_pkg::FADDR_W-1:0]         out_faddr_o
);

  localparam int AW = pfba_pkg::MAP_AW;
  localparam logic [AW-1:0] LAST_BYTE = AW'(pfba_pkg::MAP_BYTES - 1);

  logic [7:0]                     mem_q [pfba_pkg::MAP_BYTES];
  logic [pfba_pkg::MAP_BYTES-1:0] valid_q;

  logic [AW-1:0]                  rd_addr_q, rd_addr_d;
  logic [7:0]                     rd_data_q;
  logic                           rd_valid_q;
  logic                           rsv_q;
  logic [2:0]                     bit_q;

  logic                           res_ok_q;
  logic [pfba_pkg::FRAME_W-1:0]   res_page_q;
  logic [pfba_pkg::FADDR_W-1:0]   res_faddr_q;

  logic                           out_valid_q;
  logic                           out_ok_q;
  logic [pfba_pkg::FRAME_W-1:0]   out_page_q;
  logic [pfba_pkg::FADDR_W-1:0]   out_faddr_q;

  logic [7:0]                     byte_raw;
  logic [7:0]                     byte_used;
  logic [2:0]                     free_bit;
  logic [7:0]                     set_mask;
  logic [7:0]                     wr_data;
  logic [pfba_pkg::FRAME_W-1:0]   hit_page;

  // unwritten bytes read as their start-up value
  assign byte_raw  = rd_valid_q ? rd_data_q : pfba_pkg::reset_byte(rd_addr_q);
  assign byte_used = byte_raw | pfba_pkg::pad_mask(rd_addr_q);

  always_comb begin
    free_bit = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!byte_used[b]) begin
        free_bit = 3'(b);
      end
    end
  end

  assign set_mask = 8'b1 << (rsv_q ? bit_q : free_bit);
  assign wr_data  = byte_raw | set_mask;
  assign hit_page = pfba_pkg::FRAME_W'({rd_addr_q, free_bit});

  always_comb begin
    rd_addr_d = rd_addr_q;
    if (cmd_i.load) begin
      rd_addr_d = in_command_i ? AW'(in_index_i >> 3) : '0;
    end else if (cmd_i.scan_step) begin
      rd_addr_d = rd_addr_q + 1'b1;
    end
  end

  assign stat_o.in_reserve = (in_command_i == pfba_pkg::CMD_RESERVE);
  assign stat_o.in_range   = 32'(in_index_i) < pfba_pkg::FRAME_COUNT;
  assign stat_o.byte_free  = (byte_used != pfba_pkg::BYTE_FULL);
  assign stat_o.last_byte  = (rd_addr_q == LAST_BYTE);
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  // bitmap storage, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[rd_addr_q] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_d];
      rd_addr_q  <= rd_addr_d;
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsv_q       <= in_command_i;
      bit_q       <= in_index_i[2:0];
      res_ok_q    <= 1'b0;
      res_page_q  <= '0;
      res_faddr_q <= '0;
    end else if (cmd_i.commit) begin
      res_ok_q <= 1'b1;
      if (!rsv_q) begin
        res_page_q  <= hit_page;
        res_faddr_q <= pfba_pkg::FADDR_W'(32'(hit_page) * pfba_pkg::FRAME_BYTES);
      end
    end
    if (cmd_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_page_q  <= res_page_q;
      out_faddr_q <= res_faddr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_page_o  = out_page_q;
  assign out_faddr_o = out_faddr_q;

  `PFBA_ASSERT(a_load_slot, clk_i, rst_ni, cmd_i.out_load |-> (!out_valid_q || out_ready_i), "result loaded over a pending transfer")
  `PFBA_ASSERT(a_one_write, clk_i, rst_ni, cmd_i.commit |=> !cmd_i.commit, "two bitmap writes for one request")
  `PFBA_ASSERT_NEVER(a_scan_wrap, clk_i, rst_ni, cmd_i.scan_step && (rd_addr_q == LAST_BYTE), "scan stepped past end of map")

endmodule

`default_nettype wire

### sim/page_frame_bitmap_allocator_checker.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_checker
// Watches both stream channels of the allocator, keeps a shadow frame
// bitmap, predicts each grant and compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] frame_index, [15:10] zero
  input  logic        s_axis_tuser,   // [0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [9:0] page_number, [31:10] frame_address
  input  logic        m_axis_tuser,   // [0] ok
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic                         ok;
    logic [pfba_pkg::FRAME_W-1:0] page_number;
    logic [pfba_pkg::FADDR_W-1:0] frame_address;
  } grant_t;

  logic [7:0] frame_map [pfba_pkg::MAP_BYTES];
  grant_t     grants_due [$];
  grant_t     want;
  grant_t     got;
  int         mismatches;

  assign fail_count_o = mismatches;

  // lowest free frame for allocate, marks a named frame for reserve
  function automatic grant_t predict_grant(input pfba_pkg::command_e cmd,
                                           input logic [pfba_pkg::FRAME_W-1:0] idx);
    grant_t g;
    bit     found;
    int     f;
    g = '0;
    found = 1'b0;
    if (cmd == pfba_pkg::CMD_RESERVE) begin
      f = int'(idx);
      if (f < pfba_pkg::FRAME_COUNT) begin
        frame_map[f >> 3][f & 7] = 1'b1;
        g.ok = 1'b1;
      end
    end else begin
      for (int k = 0; k < pfba_pkg::MAP_BYTES && !found; k++) begin
        if (frame_map[k] != pfba_pkg::BYTE_FULL) begin
          for (int b = 0; b < 8 && !found; b++) begin
            f = 8 * k + b;
            if (f < pfba_pkg::FRAME_COUNT && !frame_map[k][b]) begin
              frame_map[k][b] = 1'b1;
              g.ok            = 1'b1;
              g.page_number   = pfba_pkg::FRAME_W'(f);
              g.frame_address = pfba_pkg::FADDR_W'(f * pfba_pkg::FRAME_BYTES);
              found           = 1'b1;
            end
          end
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // start-up reservations: kernel frames and the hardware hole
      for (int f = 0; f < pfba_pkg::FRAME_COUNT; f++) begin
        frame_map[f >> 3][f & 7] = (f < pfba_pkg::KERNEL_FRAMES) ||
                                   ((f >= pfba_pkg::HOLE_FIRST) &&
                                    (f < pfba_pkg::HOLE_LAST));
      end
      grants_due.delete();
      mismatches  = 0;
      pending_o   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_grant(pfba_pkg::command_e'(s_axis_tuser),
                             s_axis_tdata[pfba_pkg::FRAME_W-1:0]);
        grants_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok            = m_axis_tuser;
        got.page_number   = m_axis_tdata[pfba_pkg::FRAME_W-1:0];
        got.frame_address = m_axis_tdata[pfba_pkg::FRAME_W +: pfba_pkg::FADDR_W];
        if (grants_due.size() == 0) begin
          $display("%0t: expected no result, got ok %0d page %0d addr 0x%06h",
                   $time, got.ok, got.page_number, got.frame_address);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0d got %0d", $time, want.ok, got.ok);
            mismatches++;
          end
          if (got.page_number !== want.page_number) begin
            $display("%0t: page_number expected %0d got %0d",
                     $time, want.page_number, got.page_number);
            mismatches++;
          end
          if (got.frame_address !== want.frame_address) begin
            $display("%0t: frame_address expected 0x%06h got 0x%06h",
                     $time, want.frame_address, got.frame_address);
            mismatches++;
          end
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

### sim/page_frame_bitmap_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top_tb
// Drives allocate and reserve requests with random gaps and receiver stalls,
// fills the frame map to exhaustion and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_top_tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_AFTER   = 150;  // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 940;  // mostly allocations, enough to exhaust the map

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;    // [9:0] frame_index, [15:10] zero
  logic        s_axis_tuser  = 1'b0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [9:0] page_number, [31:10] frame_address
  logic        m_axis_tuser;          // [0] ok

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int rx_count     = 0;
  bit tx_burst     = 1'b0;

  always #1 clk_i = ~clk_i;

  page_frame_bitmap_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  page_frame_bitmap_allocator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // one request transfer, preceded by a random gap unless in a burst
  task automatic send_request(input pfba_pkg::command_e cmd,
                              input logic [pfba_pkg::FRAME_W-1:0] idx);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, idx};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int sent;
    pfba_pkg::command_e cmd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first free frame sits right after the kernel area
    send_request(pfba_pkg::CMD_ALLOC,   10'd0);
    send_request(pfba_pkg::CMD_RESERVE, 10'd0);      // kernel frame, already used
    send_request(pfba_pkg::CMD_RESERVE, 10'd1023);   // top of the map
    send_request(pfba_pkg::CMD_RESERVE, 10'd1023);   // same frame again
    send_request(pfba_pkg::CMD_RESERVE, 10'd33);     // just ahead of the allocator
    send_request(pfba_pkg::CMD_ALLOC,   10'd0);
    send_request(pfba_pkg::CMD_RESERVE, 10'd159);    // last frame below the hole
    send_request(pfba_pkg::CMD_RESERVE, 10'd160);    // inside the hole
    send_request(pfba_pkg::CMD_RESERVE, 10'd256);    // first frame above the hole
    send_request(pfba_pkg::CMD_ALLOC,   10'h3FF);    // index ignored on allocate
    send_request(pfba_pkg::CMD_RESERVE, 10'h2AA);
    send_request(pfba_pkg::CMD_RESERVE, 10'h155);
    for (int f = 36; f < 40; f++) begin
      send_request(pfba_pkg::CMD_RESERVE, pfba_pkg::FRAME_W'(f));
    end
    send_request(pfba_pkg::CMD_ALLOC,   10'd0);      // byte 4 now full, skipped
    send_request(pfba_pkg::CMD_ALLOC,   10'd0);      // next frame in byte 5

    // mostly allocations so the map runs out and the full case repeats
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
      end
      cmd = ($urandom_range(0, 15) == 0) ? pfba_pkg::CMD_RESERVE : pfba_pkg::CMD_ALLOC;
      send_request(cmd, pfba_pkg::FRAME_W'($urandom_range(0, pfba_pkg::FRAME_COUNT - 1)));
      sent++;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS page_frame_bitmap_allocator_top");
    end else begin
      $display("FAIL page_frame_bitmap_allocator_top");
    end
    $finish;
  end

  // receiver: random stalls, burst stretches, one long hold to back up the block
  initial begin
    int  gap;
    bit  rx_burst;
    bit  held;
    rx_burst = 1'b0;
    held     = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_count == HOLD_AFTER && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (rx_count % 40 == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rx_count++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL page_frame_bitmap_allocator_top");
      $finish;
    end
  end

endmodule

### sim.f
+incdir+src
src/pfba_pkg.sv
src/pfba_ctrl.sv
src/pfba_datapath.sv
src/page_frame_bitmap_allocator_top.sv
sim/page_frame_bitmap_allocator_checker.sv
sim/page_frame_bitmap_allocator_top_tb.sv
